### design/mouse_report_ring_refill_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mouse report ring refill block
// Immediate-consequence and next-cycle property wrappers, compiled out for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef MOUSE_REPORT_RING_REFILL_DEFINES_SVH
`define MOUSE_REPORT_RING_REFILL_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define MRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MRR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MRR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Types and constants shared by the mouse report ring refill modules.
// ----------------------------------------------------------------------------
package mrr_pkg;

   // commands on req_tuser
   localparam logic [1:0] CMD_EVENT = 2'd0;
   localparam logic [1:0] CMD_DELTA = 2'd1;
   localparam logic [1:0] CMD_PRIME = 2'd2;

   // result kinds on rsp_tuser
   localparam logic [1:0] KIND_TRB   = 2'd0;
   localparam logic [1:0] KIND_BELL  = 2'd1;
   localparam logic [1:0] KIND_DELTA = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_SLOT_ID     = 3'd0;
   localparam logic [2:0] CSR_ENDPOINT    = 3'd1;
   localparam logic [2:0] CSR_MAX_PACKET  = 3'd2;
   localparam logic [2:0] CSR_REPORT_ADDR = 3'd3;
   localparam logic [2:0] CSR_RING_BASE   = 3'd4;

   localparam logic [5:0] TRB_TYPE_XFER_EVENT = 6'd32;
   localparam logic [7:0] CC_SUCCESS          = 8'd1;

   // control word images without the cycle bit
   localparam logic [31:0] CTRL_NORMAL = 32'h0000_0420;  // type 1, IOC
   localparam logic [31:0] CTRL_LINK   = 32'h0000_1802;  // type 6, toggle cycle

   localparam int QUEUE_DEPTH = 4;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 176;

   typedef struct packed {
      logic [7:0]  slot_id;
      logic [3:0]  endpoint_number;
      logic [10:0] max_packet_size;
      logic [63:0] report_buffer_addr;
      logic [63:0] ring_base;
   } mrr_cfg_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic        is_delta;
      logic [5:0]  trb_index;
      logic [5:0]  link_index;
      logic        has_link;
      logic        cycle;
      logic [7:0]  delta_x;
      logic [7:0]  delta_y;
      logic [2:0]  buttons;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
   } mrr_job_type;

endpackage

### design/mrr_front.sv
// ----------------------------------------------------------------------------
// mrr_front
// Accepts request beats, filters transfer events, updates ring and mouse
// state and posts one job per accepted rearm or delta read.
// ----------------------------------------------------------------------------
module mrr_front
   import mrr_pkg::*;
#(
   parameter int RING_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            cfg_slot_id,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  job_push,
   output mrr_job_type           job,
   input  logic                  job_ready
);

   localparam int IDX_W = $clog2(RING_ENTRIES);
   localparam logic [IDX_W-1:0] LINK_AT = IDX_W'(RING_ENTRIES - 2);

   logic [IDX_W-1:0] enq_idx_ff, enq_idx_in;
   logic             cycle_ff, cycle_in;
   logic [15:0]      pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [7:0]       held_dx_ff, held_dx_in, held_dy_ff, held_dy_in;
   logic [2:0]       held_btn_ff, held_btn_in;

   logic [5:0] event_type;
   logic [7:0] completion_code, event_slot, button_byte, dx, dy;
   logic       report_present;
   logic       accept, event_ok, do_rearm, do_delta, has_link;
   logic [IDX_W:0] idx_plus;

   assign event_type      = req_tdata[5:0];
   assign completion_code = req_tdata[13:6];
   assign event_slot      = req_tdata[21:14];
   assign report_present  = req_tdata[22];
   assign button_byte     = req_tdata[30:23];
   assign dx              = req_tdata[38:31];
   assign dy              = req_tdata[46:39];

   assign req_tready = job_ready;
   assign accept     = req_tvalid && req_tready;

   assign event_ok = (req_tuser == CMD_EVENT) && (event_type == TRB_TYPE_XFER_EVENT) &&
                     (completion_code == CC_SUCCESS) && (event_slot == cfg_slot_id);
   assign do_rearm = accept && (event_ok || (req_tuser == CMD_PRIME));
   assign do_delta = accept && (req_tuser == CMD_DELTA);
   assign job_push = do_rearm || do_delta;

   assign idx_plus = {1'b0, enq_idx_ff} + 1'b1;
   assign has_link = (enq_idx_ff >= LINK_AT);

   always_comb begin
      job.is_delta   = do_delta;
      job.trb_index  = 6'(enq_idx_ff);
      job.link_index = 6'(idx_plus);
      job.has_link   = has_link;
      job.cycle      = cycle_ff;
      job.delta_x    = held_dx_ff;
      job.delta_y    = held_dy_ff;
      job.buttons    = held_btn_ff;
      job.pos_x      = pos_x_ff;
      job.pos_y      = pos_y_ff;
   end

   always_comb begin
      enq_idx_in  = enq_idx_ff;
      cycle_in    = cycle_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      held_dx_in  = held_dx_ff;
      held_dy_in  = held_dy_ff;
      held_btn_in = held_btn_ff;
      if (do_rearm) begin
         if (has_link) begin
            enq_idx_in = '0;
            cycle_in   = !cycle_ff;
         end else begin
            enq_idx_in = idx_plus[IDX_W-1:0];
         end
      end
      // latch report and accumulate with 16-bit wrap
      if (do_rearm && event_ok && report_present) begin
         held_btn_in = button_byte[2:0];
         held_dx_in  = dx;
         held_dy_in  = dy;
         pos_x_in    = pos_x_ff + {{8{dx[7]}}, dx};
         pos_y_in    = pos_y_ff + {{8{dy[7]}}, dy};
      end
      if (do_delta) begin
         held_btn_in = '0;
         held_dx_in  = '0;
         held_dy_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enq_idx_ff  <= '0;
         cycle_ff    <= 1'b1;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         held_dx_ff  <= '0;
         held_dy_ff  <= '0;
         held_btn_ff <= '0;
      end else begin
         enq_idx_ff  <= enq_idx_in;
         cycle_ff    <= cycle_in;
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         held_dx_ff  <= held_dx_in;
         held_dy_ff  <= held_dy_in;
         held_btn_ff <= held_btn_in;
      end
   end

endmodule

### design/mrr_queue.sv
// ----------------------------------------------------------------------------
// mrr_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module mrr_queue
   import mrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  mrr_job_type push_job,
   output logic        push_ready,
   input  logic        pop,
   output mrr_job_type pop_job,
   output logic        pop_valid
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   mrr_job_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];

   assign do_push = push && push_ready;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/mrr_back.sv
// ----------------------------------------------------------------------------
// mrr_back
// Expands each job into its response beats (normal TRB, optional link TRB,
// doorbell, or a single delta answer) behind a registered output stage.
// ----------------------------------------------------------------------------
module mrr_back
   import mrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  mrr_cfg_type           cfg,
   input  logic                  job_valid,
   input  mrr_job_type           job,
   output logic                  job_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_LINK  = 2'd1;
   localparam logic [1:0] PH_BELL  = 2'd2;

   mrr_job_type           cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        load_ok, emit, final_beat, take;
   logic [5:0]  b_index;
   logic [63:0] b_param;
   logic [10:0] b_status;
   logic [31:0] b_control;
   logic [4:0]  b_bell;
   logic [7:0]  b_dx, b_dy;
   logic [2:0]  b_btn;
   logic [15:0] b_px, b_py;

   assign load_ok    = !rsp_valid_ff || rsp_tready;
   assign emit       = cur_valid_ff && load_ok;
   assign final_beat = cur_ff.is_delta || (phase_ff == PH_BELL);
   assign take       = job_valid && (!cur_valid_ff || (emit && final_beat));
   assign job_pop    = take;

   // build the beat for the current phase; unused fields stay zero
   always_comb begin
      rsp_kind_in = KIND_TRB;
      rsp_last_in = 1'b0;
      b_index     = '0;
      b_param     = '0;
      b_status    = '0;
      b_control   = '0;
      b_bell      = '0;
      b_dx        = '0;
      b_dy        = '0;
      b_btn       = '0;
      b_px        = '0;
      b_py        = '0;
      if (cur_ff.is_delta) begin
         rsp_kind_in = KIND_DELTA;
         rsp_last_in = 1'b1;
         b_dx        = cur_ff.delta_x;
         b_dy        = cur_ff.delta_y;
         b_btn       = cur_ff.buttons;
         b_px        = cur_ff.pos_x;
         b_py        = cur_ff.pos_y;
      end else begin
         case (phase_ff)
            PH_FIRST: begin
               b_index   = cur_ff.trb_index;
               b_param   = cfg.report_buffer_addr;
               b_status  = cfg.max_packet_size;
               b_control = CTRL_NORMAL | {31'd0, cur_ff.cycle};
            end
            PH_LINK: begin
               b_index   = cur_ff.link_index;
               b_param   = cfg.ring_base;
               b_control = CTRL_LINK | {31'd0, cur_ff.cycle};
            end
            default: begin
               rsp_kind_in = KIND_BELL;
               rsp_last_in = 1'b1;
               b_bell      = {cfg.endpoint_number, 1'b1};
            end
         endcase
      end
      rsp_data_in = {7'd0, b_py, b_px, b_btn, b_dy, b_dx, b_bell,
                     b_control, b_status, b_param, b_index};
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      if (emit) begin
         case (phase_ff)
            PH_FIRST: phase_in = cur_ff.has_link ? PH_LINK : PH_BELL;
            PH_LINK:  phase_in = PH_BELL;
            default:  phase_in = PH_FIRST;
         endcase
         if (final_beat) begin
            cur_valid_in = 1'b0;
         end
      end
      if (take) begin
         cur_in       = job;
         cur_valid_in = 1'b1;
         phase_in     = PH_FIRST;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold until the next beat is emitted
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/mouse_report_ring_refill.sv
// ----------------------------------------------------------------------------
// mouse_report_ring_refill
// Transfer-ring producer for a boot-protocol HID mouse.
// ----------------------------------------------------------------------------
// The request side takes one beat per cycle while the four-entry job queue
// has room; filtered-out events and unknown commands are taken and dropped.
// A successful transfer event or a prime request yields a normal TRB write,
// a link TRB write when the ring wraps, then a doorbell write: two or three
// response beats. A delta read yields one beat. The sustained rate is set
// by the response stage, which sends one beat per cycle while rsp_tready is
// high. Mouse state and the enqueue index are updated at request acceptance,
// so a delta read reflects every event accepted before it.
module mouse_report_ring_refill
   import mrr_pkg::*;
#(
   parameter int RING_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wen,
   input  logic [2:0]            csr_addr,
   input  logic [63:0]           csr_wdata,
   // requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // command
   // event_type[5:0], completion_code[13:6], event_slot[21:14],
   // report_present[22], report_button_byte[30:23], report_dx[38:31],
   // report_dy[46:39], zero[47]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // responses
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,   // result_kind
   output logic                  rsp_tlast,
   // trb_index[5:0], trb_parameter[69:6], trb_status[80:70],
   // trb_control[112:81], doorbell_value[117:113], delta_x[125:118],
   // delta_y[133:126], button_bits[136:134], position_x[152:137],
   // position_y[168:153], zero[175:169]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

`include "mouse_report_ring_refill_defines.svh"

   mrr_cfg_type cfg_ff, cfg_in;
   mrr_job_type push_job, pop_job;
   logic        job_push, job_ready, job_pop, job_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_SLOT_ID:     cfg_in.slot_id            = csr_wdata[7:0];
            CSR_ENDPOINT:    cfg_in.endpoint_number    = csr_wdata[3:0];
            CSR_MAX_PACKET:  cfg_in.max_packet_size    = csr_wdata[10:0];
            CSR_REPORT_ADDR: cfg_in.report_buffer_addr = csr_wdata;
            CSR_RING_BASE:   cfg_in.ring_base          = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_id            <= 8'd1;
         cfg_ff.endpoint_number    <= 4'd1;
         cfg_ff.max_packet_size    <= 11'd8;
         cfg_ff.report_buffer_addr <= '0;
         cfg_ff.ring_base          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mrr_front #(
      .RING_ENTRIES (RING_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_slot_id (cfg_ff.slot_id),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .job_push    (job_push),
      .job         (push_job),
      .job_ready   (job_ready)
   );

   mrr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .push_ready (job_ready),
      .pop        (job_pop),
      .pop_job    (pop_job),
      .pop_valid  (job_valid)
   );

   mrr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (pop_job),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   `MRR_ASSERT_IMPL(a_trb_not_last, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_TRB), !rsp_tlast)
   `MRR_ASSERT_IMPL(a_bell_last, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_BELL), rsp_tlast)
   `MRR_ASSERT_IMPL(a_push_has_room, clock, reset, job_push, job_ready)
   `MRR_ASSERT_NEXT(a_trb_followed, clock, reset,
      rsp_tvalid && rsp_tready && (rsp_tuser == KIND_TRB), rsp_tvalid)

endmodule

### tb/sv/mouse_report_ring_refill_tb.sv
// ----------------------------------------------------------------------------
// mouse_report_ring_refill_tb
// Self-checking bench for the mouse report ring refill block. A queue-fed
// driver sends transfer events, delta reads, prime requests and noise with
// random gaps. A monitor applies random back-pressure and checks every
// response beat, field by field, against a predictor of the ring and the
// mouse state. Several register settings are used, the extremes among them.
// ----------------------------------------------------------------------------
module mouse_report_ring_refill_tb
   import mrr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS     = 64;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 62;

   typedef struct {
      logic [1:0] cmd;
      logic [5:0] trb_type;
      logic [7:0] ccode;
      logic [7:0] slot;
      logic       present;
      logic [7:0] btn_byte;
      logic [7:0] dx;
      logic [7:0] dy;
   } mouse_req_type;

   typedef struct {
      logic [1:0]  kind;
      logic        last;
      logic [5:0]  trb_index;
      logic [63:0] trb_param;
      logic [10:0] trb_status;
      logic [31:0] trb_control;
      logic [4:0]  doorbell;
      logic [7:0]  delta_x;
      logic [7:0]  delta_y;
      logic [2:0]  buttons;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [6:0]  pad;
   } rsp_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [2:0]            csr_addr = '0;
   logic [63:0]           csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   mouse_report_ring_refill #(
      .RING_ENTRIES(RING_SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   // register mirror
   logic [7:0]  cfg_slot        = 8'd1;
   logic [3:0]  cfg_endpoint    = 4'd1;
   logic [10:0] cfg_max_packet  = 11'd8;
   logic [63:0] cfg_report_addr = '0;
   logic [63:0] cfg_ring_base   = '0;

   // ring and mouse state mirror
   int          ring_slot    = 0;
   logic        ring_cycle   = 1'b1;
   logic [15:0] pos_x_sum    = '0;
   logic [15:0] pos_y_sum    = '0;
   logic [7:0]  latched_dx   = '0;
   logic [7:0]  latched_dy   = '0;
   logic [2:0]  latched_btns = '0;

   mouse_req_type req_backlog[$];
   rsp_beat_type  rsp_due[$];
   mouse_req_type req_on_bus;
   int            error_count = 0;
   bit            calm = 1'b0;
   int            req_gap = 0;
   int            rsp_gap = 0;
   int            quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic rsp_beat_type blank_beat(logic [1:0] kind);
      rsp_beat_type b;
      b = '{default: '0};
      b.kind = kind;
      return b;
   endfunction

   // queue normal TRB, optional link TRB, then the doorbell
   task automatic queue_rearm();
      rsp_beat_type b;
      b = blank_beat(KIND_TRB);
      b.trb_index   = ring_slot[5:0];
      b.trb_param   = cfg_report_addr;
      b.trb_status  = cfg_max_packet;
      b.trb_control = CTRL_NORMAL | {31'd0, ring_cycle};
      rsp_due.push_back(b);
      ring_slot++;
      if (ring_slot >= RING_SLOTS - 1) begin
         b = blank_beat(KIND_TRB);
         b.trb_index   = ring_slot[5:0];
         b.trb_param   = cfg_ring_base;
         b.trb_control = CTRL_LINK | {31'd0, ring_cycle};
         rsp_due.push_back(b);
         ring_slot  = 0;
         ring_cycle = ~ring_cycle;
      end
      b = blank_beat(KIND_BELL);
      b.doorbell = {cfg_endpoint, 1'b1};
      b.last     = 1'b1;
      rsp_due.push_back(b);
   endtask

   task automatic apply_request(mouse_req_type q);
      rsp_beat_type b;
      case (q.cmd)
         CMD_EVENT: begin
            if (q.trb_type == TRB_TYPE_XFER_EVENT && q.ccode == CC_SUCCESS &&
                q.slot == cfg_slot) begin
               if (q.present) begin
                  pos_x_sum    = pos_x_sum + {{8{q.dx[7]}}, q.dx};
                  pos_y_sum    = pos_y_sum + {{8{q.dy[7]}}, q.dy};
                  latched_dx   = q.dx;
                  latched_dy   = q.dy;
                  latched_btns = q.btn_byte[2:0];
               end
               queue_rearm();
            end
         end
         CMD_DELTA: begin
            b = blank_beat(KIND_DELTA);
            b.delta_x = latched_dx;
            b.delta_y = latched_dy;
            b.buttons = latched_btns;
            b.pos_x   = pos_x_sum;
            b.pos_y   = pos_y_sum;
            b.last    = 1'b1;
            rsp_due.push_back(b);
            latched_dx   = '0;
            latched_dy   = '0;
            latched_btns = '0;
         end
         CMD_PRIME: queue_rearm();
         default: ;
      endcase
   endtask

   function automatic mouse_req_type good_event(logic [7:0] btn, logic [7:0] dx,
                                                logic [7:0] dy, logic present);
      mouse_req_type q;
      q.cmd      = CMD_EVENT;
      q.trb_type = TRB_TYPE_XFER_EVENT;
      q.ccode    = CC_SUCCESS;
      q.slot     = cfg_slot;
      q.present  = present;
      q.btn_byte = btn;
      q.dx       = dx;
      q.dy       = dy;
      return q;
   endfunction

   function automatic mouse_req_type noise_req(logic [1:0] cmd);
      mouse_req_type q;
      q.cmd      = cmd;
      q.trb_type = 6'($urandom);
      q.ccode    = 8'($urandom);
      q.slot     = 8'($urandom);
      q.present  = 1'($urandom);
      q.btn_byte = 8'($urandom);
      q.dx       = 8'($urandom);
      q.dy       = 8'($urandom);
      return q;
   endfunction

   function automatic logic [7:0] pick_motion();
      case ($urandom_range(0, 9))
         0: return 8'h7F;
         1: return 8'h80;
         2: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic mouse_req_type random_req();
      mouse_req_type q;
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         q = good_event(8'($urandom), pick_motion(), pick_motion(),
                        $urandom_range(0, 9) != 0);
      end else if (r < 65) begin
         q = noise_req(CMD_DELTA);
      end else if (r < 73) begin
         q = noise_req(CMD_PRIME);
      end else if (r < 88) begin
         // near miss: one filter field off
         q = good_event(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
         case ($urandom_range(0, 2))
            0: q.trb_type = q.trb_type ^ 6'($urandom_range(1, 63));
            1: q.ccode    = q.ccode ^ 8'($urandom_range(1, 255));
            default: q.slot = q.slot ^ 8'($urandom_range(1, 255));
         endcase
      end else begin
         q = noise_req(2'($urandom_range(0, 3)));
      end
      return q;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(req_on_bus);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_on_bus = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_on_bus.cmd;
               req_tdata  <= {1'b0, req_on_bus.dy, req_on_bus.dx, req_on_bus.btn_byte,
                              req_on_bus.present, req_on_bus.slot, req_on_bus.ccode,
                              req_on_bus.trb_type};
               req_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
   endtask

   task automatic check_beat(rsp_beat_type e);
      rsp_beat_type a;
      a.kind        = rsp_tuser;
      a.last        = rsp_tlast;
      a.trb_index   = rsp_tdata[5:0];
      a.trb_param   = rsp_tdata[69:6];
      a.trb_status  = rsp_tdata[80:70];
      a.trb_control = rsp_tdata[112:81];
      a.doorbell    = rsp_tdata[117:113];
      a.delta_x     = rsp_tdata[125:118];
      a.delta_y     = rsp_tdata[133:126];
      a.buttons     = rsp_tdata[136:134];
      a.pos_x       = rsp_tdata[152:137];
      a.pos_y       = rsp_tdata[168:153];
      a.pad         = rsp_tdata[175:169];
      if (a.kind !== e.kind) report_field("result_kind", e.kind, a.kind);
      if (a.last !== e.last) report_field("last", e.last, a.last);
      if (a.trb_index !== e.trb_index) report_field("trb_index", e.trb_index, a.trb_index);
      if (a.trb_param !== e.trb_param) report_field("trb_parameter", e.trb_param, a.trb_param);
      if (a.trb_status !== e.trb_status)
         report_field("trb_status", e.trb_status, a.trb_status);
      if (a.trb_control !== e.trb_control)
         report_field("trb_control", e.trb_control, a.trb_control);
      if (a.doorbell !== e.doorbell) report_field("doorbell_value", e.doorbell, a.doorbell);
      if (a.delta_x !== e.delta_x) report_field("delta_x", e.delta_x, a.delta_x);
      if (a.delta_y !== e.delta_y) report_field("delta_y", e.delta_y, a.delta_y);
      if (a.buttons !== e.buttons) report_field("button_bits", e.buttons, a.buttons);
      if (a.pos_x !== e.pos_x) report_field("position_x", e.pos_x, a.pos_x);
      if (a.pos_y !== e.pos_y) report_field("position_y", e.pos_y, a.pos_y);
      if (a.pad !== e.pad) report_field("padding", e.pad, a.pad);
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_due.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual kind %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               check_beat(rsp_due.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d beats outstanding", $time, rsp_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] addr, logic [63:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
   endtask

   task automatic program_regs(logic [7:0] slot, logic [3:0] ep, logic [10:0] mps,
                               logic [63:0] raddr, logic [63:0] rbase);
      write_reg(CSR_SLOT_ID, {56'd0, slot});
      write_reg(CSR_ENDPOINT, {60'd0, ep});
      write_reg(CSR_MAX_PACKET, {53'd0, mps});
      write_reg(CSR_REPORT_ADDR, raddr);
      write_reg(CSR_RING_BASE, rbase);
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_slot        = slot;
      cfg_endpoint    = ep;
      cfg_max_packet  = mps;
      cfg_report_addr = raddr;
      cfg_ring_base   = rbase;
   endtask

   // hold until every beat is sent and every response has arrived
   task automatic wait_idle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || rsp_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      mouse_req_type q;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part under reset settings
      req_backlog.push_back(noise_req(CMD_PRIME));
      req_backlog.push_back(good_event(8'hFF, 8'h7F, 8'h7F, 1'b1));
      req_backlog.push_back(noise_req(CMD_DELTA));
      req_backlog.push_back(good_event(8'h00, 8'h80, 8'h80, 1'b1));
      req_backlog.push_back(good_event(8'hF8, 8'h01, 8'hFF, 1'b1));
      req_backlog.push_back(noise_req(CMD_DELTA));
      // missing report: only re-arm
      req_backlog.push_back(good_event(8'h07, 8'h55, 8'hAA, 1'b0));
      req_backlog.push_back(noise_req(CMD_DELTA));
      req_backlog.push_back(noise_req(CMD_DELTA));
      // rejected events
      q = good_event(8'h05, 8'h10, 8'h20, 1'b1);
      q.trb_type = 6'd0;
      req_backlog.push_back(q);
      q.trb_type = 6'h3F;
      req_backlog.push_back(q);
      q = good_event(8'h05, 8'h10, 8'h20, 1'b1);
      q.ccode = 8'd0;
      req_backlog.push_back(q);
      q.ccode = 8'hFF;
      req_backlog.push_back(q);
      q = good_event(8'h05, 8'h10, 8'h20, 1'b1);
      q.slot = 8'd0;
      req_backlog.push_back(q);
      q.slot = 8'hFF;
      req_backlog.push_back(q);
      req_backlog.push_back(noise_req(2'd3));
      req_backlog.push_back(noise_req(CMD_DELTA));
      req_backlog.push_back(good_event(8'h02, 8'h7F, 8'h80, 1'b1));
      req_backlog.push_back(noise_req(CMD_PRIME));
      req_backlog.push_back(noise_req(CMD_DELTA));
      wait_idle();

      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: program_regs(8'hFF, 4'hF, 11'd1024, '1, '1);
            2: program_regs(8'd1, 4'd1, 11'd0, '0, '0);
            default: program_regs(8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)),
                                  11'($urandom_range(0, 1024)), {$urandom, $urandom},
                                  {$urandom, $urandom});
         endcase
         calm = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) req_backlog.push_back(random_req());
         wait_idle();
      end

      if (error_count == 0 && rsp_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### mouse_report_ring_refill.f
+incdir+design
design/mrr_pkg.sv
design/mrr_front.sv
design/mrr_queue.sv
design/mrr_back.sv
design/mouse_report_ring_refill.sv
tb/sv/mouse_report_ring_refill_tb.sv
